FILE: design/led_two_color_gradient_unit_macros.svh
// assertion macros shared by the led two color gradient unit
// no dependencies; included by lgcg_back, the file that checks its own logic
`ifndef LED_TWO_COLOR_GRADIENT_UNIT_MACROS_SVH
`define LED_TWO_COLOR_GRADIENT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LGCG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgcg assertion failed");
// next-cycle implication
`define LGCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgcg assertion failed");
`else
`define LGCG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LGCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/lgcg_pkg.sv
// types and constants of the led two color gradient unit
// no dependencies; used by front, queue, back and top level
package lgcg_pkg;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int OFF_W = 8;
    localparam int CH_W = 8;
    localparam int COL_W = 24;
    localparam int X_W = CNT_W + OFF_W;
    localparam int REG_IDX_W = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int MAX_LEDS = 1024;

    // reciprocal of 255 for the middle point quotient
    localparam int DIV255_SHIFT = 27;
    localparam int MUL_W = 20;
    localparam logic [MUL_W-1:0] DIV255_MUL = MUL_W'((64'd1 << DIV255_SHIFT) / 255);

    // mode codes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_CENTER = 2'd1;
    localparam logic [1:0] MODE_SOLID = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REVERSE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COUNT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_FIRST = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_SECOND = 3'd4;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_SOLID,
        CLS_TWO,
        CLS_LINEAR,
        CLS_CENTER
    } cls_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             reverse_order;
        logic [CNT_W-1:0] led_count;
        logic [COL_W-1:0] color_first;
        logic [COL_W-1:0] color_second;
    } cfg_t;

    typedef struct packed {
        cls_t             cls;
        logic [IDX_W-1:0] pixel_index;
        logic [IDX_W-1:0] pos_idx;
        logic [CNT_W-1:0] cnt_m1;
        logic [X_W-1:0]   prod;
        logic [OFF_W-1:0] two_sel;
        logic             two_full;
        logic             two_inv;
    } item_t;

    // floor(r * 2^fb / 255), evaluated at elaboration only
    function automatic longint unsigned frac_of_255(input int unsigned r,
                                                     input int unsigned fb);
        return (longint'(r) << fb) / 255;
    endfunction

endpackage

FILE: design/lgcg_fifo.sv
// short queue of classified items between front and back
// depends on lgcg_pkg
module lgcg_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lgcg_pkg::item_t push_item,
    input  logic           pop,
    output lgcg_pkg::item_t head_item,
    output logic           not_empty,
    output logic           full
);
    import lgcg_pkg::*;

    item_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign not_empty = (count_reg != '0);
    assign full = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;
    assign head_item = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/lgcg_front.sv
// front end: accepts led requests and classifies them for the back end
// depends on lgcg_pkg
module lgcg_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lgcg_pkg::cfg_t             cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lgcg_pkg::OFF_W-1:0] offset,
    input  logic [lgcg_pkg::IDX_W-1:0] led_index,
    output logic                       push,
    output lgcg_pkg::item_t            push_item,
    input  logic                       fifo_full
);
    import lgcg_pkg::*;

    logic             valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic             accept;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] nm1;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] ridx;
    logic             low_half;
    logic [OFF_W-1:0] dbl;

    assign in_stall = valid_reg && fifo_full;
    assign accept = in_valid && !in_stall;
    assign push = valid_reg;
    assign push_item = item_reg;

    // classification of one request
    always_comb
    begin
        if (cfg.led_count == '0)
        begin
            n = CNT_W'(1);
        end
        else if (cfg.led_count > CNT_W'(MAX_LEDS))
        begin
            n = CNT_W'(MAX_LEDS);
        end
        else
        begin
            n = cfg.led_count;
        end
        nm1 = n - 1'b1;
        idx_ext = {1'b0, led_index};
        ridx = cfg.reverse_order ? (nm1 - idx_ext) : idx_ext;
        low_half = !offset[OFF_W-1];
        dbl = {offset[OFF_W-2:0], 1'b0};

        item_next.pixel_index = led_index;
        item_next.pos_idx = ridx[IDX_W-1:0];
        item_next.cnt_m1 = nm1;
        item_next.prod = X_W'(nm1 * offset);
        item_next.two_sel = low_half ? (8'd255 - dbl) : (dbl - 8'd255);
        item_next.two_full = low_half ^ (ridx != '0);
        item_next.two_inv = !low_half;

        if (idx_ext >= n)
        begin
            item_next.cls = CLS_ZERO;
        end
        else if (n == CNT_W'(2))
        begin
            item_next.cls = CLS_TWO;
        end
        else if (n == CNT_W'(1))
        begin
            item_next.cls = CLS_SOLID;
        end
        else
        begin
            case (cfg.mode)
                MODE_LINEAR: item_next.cls = CLS_LINEAR;
                MODE_CENTER: item_next.cls = CLS_CENTER;
                default:     item_next.cls = CLS_SOLID;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!fifo_full)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: design/lgcg_back.sv
// back end: middle point, blend position divider and color blend pipeline
// depends on lgcg_pkg and the assertion macro header
`include "led_two_color_gradient_unit_macros.svh"
module lgcg_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lgcg_pkg::cfg_t             cfg,
    input  lgcg_pkg::item_t            head_item,
    input  logic                       not_empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lgcg_pkg::CH_W-1:0]  red,
    output logic [lgcg_pkg::CH_W-1:0]  green,
    output logic [lgcg_pkg::CH_W-1:0]  blue,
    output logic [lgcg_pkg::IDX_W-1:0] pixel_index
);
    import lgcg_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int W = CNT_W + FB;
    localparam int PW = FB + 1;
    localparam int VW = PW + CH_W + 1;
    localparam logic [PW-1:0] ONE_FX = PW'(64'd1 << FB);
    localparam logic [PW-1:0] HALF_FX = PW'(64'd1 << (FB - 1));
    localparam logic [W-1:0] HUND_FX = W'((64'd1 << FB) / 100);

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             fixed;
        logic             linear;
        logic             high;
        logic [IDX_W-1:0] pixel_index;
    } ctl_t;

    logic en;
    logic [PW-1:0] frac_tbl [256];

    // constant table of r * 2^FB / 255
    for (genvar g = 0; g < 256; g++)
    begin : g_tbl
        localparam longint unsigned V = frac_of_255(g, FB);
        assign frac_tbl[g] = V[PW-1:0];
    end

    assign en = !out_valid || !out_stall;
    assign pop = en && not_empty;

    // stage 1: quotient estimate and fixed positions
    ctl_t             s1_ctl_reg;
    ctl_t             s1_ctl_next;
    logic [PW-1:0]    s1_pos_reg;
    logic [PW-1:0]    s1_pos_next;
    logic [X_W-1:0]   s1_prod_reg;
    logic [CNT_W-1:0] s1_qe_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [CNT_W-1:0] s1_nm1_reg;
    logic [X_W+MUL_W-1:0] s1_mul;
    logic [PW-1:0]    two_p;

    always_comb
    begin
        s1_ctl_next.valid = not_empty;
        s1_ctl_next.zero = (head_item.cls == CLS_ZERO);
        s1_ctl_next.fixed = head_item.cls inside {CLS_ZERO, CLS_SOLID, CLS_TWO};
        s1_ctl_next.linear = (head_item.cls == CLS_LINEAR);
        s1_ctl_next.high = 1'b0;
        s1_ctl_next.pixel_index = head_item.pixel_index;
        two_p = head_item.two_full ? ONE_FX : frac_tbl[head_item.two_sel];
        if (head_item.cls == CLS_TWO)
        begin
            s1_pos_next = head_item.two_inv ? (ONE_FX - two_p) : two_p;
        end
        else
        begin
            s1_pos_next = '0;
        end
        s1_mul = (X_W+MUL_W)'(head_item.prod * DIV255_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pos_reg <= s1_pos_next;
            s1_prod_reg <= head_item.prod;
            s1_qe_reg <= s1_mul[DIV255_SHIFT +: CNT_W];
            s1_idx_reg <= head_item.pos_idx;
            s1_nm1_reg <= head_item.cnt_m1;
        end
    end

    // stage 2: quotient correction, remainder of the divide by 255
    ctl_t             s2_ctl_reg;
    logic [PW-1:0]    s2_pos_reg;
    logic [CNT_W-1:0] s2_q_reg;
    logic [7:0]       s2_r_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [CNT_W-1:0] s2_nm1_reg;
    logic [X_W-1:0]   s2_rem;
    logic             s2_ge;

    assign s2_rem = s1_prod_reg - X_W'(s1_qe_reg * 8'd255);
    assign s2_ge = (s2_rem >= X_W'(255));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else if (en)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pos_reg <= s1_pos_reg;
            s2_q_reg <= s2_ge ? (s1_qe_reg + 1'b1) : s1_qe_reg;
            s2_r_reg <= s2_ge ? 8'(s2_rem - X_W'(255)) : s2_rem[7:0];
            s2_idx_reg <= s1_idx_reg;
            s2_nm1_reg <= s1_nm1_reg;
        end
    end

    // stage 3: middle point and clamp
    ctl_t          s3_ctl_reg;
    logic [PW-1:0] s3_pos_reg;
    logic [W-1:0]  s3_mid_reg;
    logic [W-1:0]  s3_ifx_reg;
    logic [W-1:0]  s3_last_reg;
    logic [W-1:0]  s3_raw;
    logic [W-1:0]  s3_last;
    logic [W-1:0]  s3_hi;
    logic [W-1:0]  s3_mid;

    always_comb
    begin
        s3_raw = {s2_q_reg, frac_tbl[s2_r_reg][FB-1:0]};
        s3_last = {s2_nm1_reg, {FB{1'b0}}};
        s3_hi = s3_last - HUND_FX;
        if (s3_raw < HUND_FX)
        begin
            s3_mid = HUND_FX;
        end
        else if (s3_raw > s3_hi)
        begin
            s3_mid = s3_hi;
        end
        else
        begin
            s3_mid = s3_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else if (en)
        begin
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_pos_reg <= s2_pos_reg;
            s3_mid_reg <= s3_mid;
            s3_ifx_reg <= {(CNT_W-IDX_W)'(0), s2_idx_reg, {FB{1'b0}}};
            s3_last_reg <= s3_last;
        end
    end

    // stage 4: side of the middle and differences
    ctl_t          s4_ctl_reg;
    logic [PW-1:0] s4_pos_reg;
    logic          s4_lt_reg;
    logic [W-1:0]  s4_mid_reg;
    logic [W-1:0]  s4_ifx_reg;
    logic [W-1:0]  s4_num_reg;
    logic [W-1:0]  s4_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_ctl_reg <= '0;
        end
        else if (en)
        begin
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_pos_reg <= s3_pos_reg;
            s4_lt_reg <= (s3_ifx_reg < s3_mid_reg);
            s4_mid_reg <= s3_mid_reg;
            s4_ifx_reg <= s3_ifx_reg;
            s4_num_reg <= s3_ifx_reg - s3_mid_reg;
            s4_den_reg <= s3_last_reg - s3_mid_reg;
        end
    end

    // stage 5: divider operands
    ctl_t          s5_ctl_reg;
    ctl_t          s5_ctl_next;
    logic [PW-1:0] s5_pos_reg;
    logic [W-1:0]  s5_a_reg;
    logic [W-1:0]  s5_b_reg;
    logic [W-1:0]  s5_num;

    always_comb
    begin
        s5_ctl_next = s4_ctl_reg;
        s5_ctl_next.high = !s4_lt_reg;
        s5_num = (s4_num_reg > s4_den_reg) ? s4_den_reg : s4_num_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_ctl_reg <= '0;
        end
        else if (en)
        begin
            s5_ctl_reg <= s5_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_pos_reg <= s4_pos_reg;
            s5_a_reg <= s4_lt_reg ? s4_ifx_reg : s5_num;
            s5_b_reg <= s4_lt_reg ? s4_mid_reg : s4_den_reg;
        end
    end

    // divider: integer bit, then one fraction bit per stage
    ctl_t          dv_ctl_reg [FB+1];
    logic [PW-1:0] dv_pos_reg [FB+1];
    logic [W-1:0]  dv_r_reg [FB+1];
    logic [W-1:0]  dv_b_reg [FB+1];
    logic [PW-1:0] dv_q_reg [FB+1];
    logic          dv0_ge;

    assign dv0_ge = (s5_a_reg >= s5_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            dv_ctl_reg[0] <= s5_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_pos_reg[0] <= s5_pos_reg;
            dv_b_reg[0] <= s5_b_reg;
            dv_r_reg[0] <= dv0_ge ? (s5_a_reg - s5_b_reg) : s5_a_reg;
            dv_q_reg[0] <= PW'(dv0_ge);
        end
    end

    for (genvar k = 1; k <= FB; k++)
    begin : g_div
        logic [W:0] r2;
        logic [W:0] diff;
        logic       ge;

        assign r2 = {dv_r_reg[k-1], 1'b0};
        assign diff = r2 - {1'b0, dv_b_reg[k-1]};
        assign ge = (r2 >= {1'b0, dv_b_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                dv_ctl_reg[k] <= dv_ctl_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_pos_reg[k] <= dv_pos_reg[k-1];
                dv_b_reg[k] <= dv_b_reg[k-1];
                dv_r_reg[k] <= ge ? diff[W-1:0] : r2[W-1:0];
                dv_q_reg[k] <= {dv_q_reg[k-1][PW-2:0], ge};
            end
        end
    end

    // blend position from quotient and mode
    ctl_t          p_ctl_reg;
    logic [PW-1:0] p_pos_reg;
    logic [PW-1:0] p_pos;
    logic [PW-1:0] p_q;

    always_comb
    begin
        p_q = dv_q_reg[FB];
        if (dv_ctl_reg[FB].fixed)
        begin
            p_pos = dv_pos_reg[FB];
        end
        else if (dv_ctl_reg[FB].linear)
        begin
            p_pos = dv_ctl_reg[FB].high ? (HALF_FX + (p_q >> 1)) : (p_q >> 1);
        end
        else
        begin
            p_pos = dv_ctl_reg[FB].high ? (ONE_FX - p_q) : p_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctl_reg <= '0;
        end
        else if (en)
        begin
            p_ctl_reg <= dv_ctl_reg[FB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_pos_reg <= p_pos;
        end
    end

    // color blend and output register
    logic [CH_W-1:0] ch_next [3];
    logic [VW-1:0]   v [3];
    logic [CH_W-1:0] c1 [3];
    logic [CH_W-1:0] c2 [3];
    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] green_reg;
    logic [CH_W-1:0] blue_reg;
    logic [IDX_W-1:0] pixel_index_reg;
    logic            out_valid_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            c1[j] = cfg.color_first[(2-j)*CH_W +: CH_W];
            c2[j] = cfg.color_second[(2-j)*CH_W +: CH_W];
            v[j] = VW'(p_pos_reg * c2[j]) + VW'((ONE_FX - p_pos_reg) * c1[j]);
            ch_next[j] = p_ctl_reg.zero ? '0 : v[j][FB +: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg <= ch_next[0];
            green_reg <= ch_next[1];
            blue_reg <= ch_next[2];
            pixel_index_reg <= p_ctl_reg.pixel_index;
        end
    end

    assign out_valid = out_valid_reg;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;
    assign pixel_index = pixel_index_reg;

    // checks
    `LGCG_ASSERT_IMP(a_div_range, clk, rst_n, dv_ctl_reg[FB].valid && !dv_ctl_reg[FB].fixed, dv_q_reg[FB] <= ONE_FX)
    `LGCG_ASSERT_IMP(a_mid_clamp, clk, rst_n, s3_ctl_reg.valid && !s3_ctl_reg.fixed, (s3_mid_reg >= HUND_FX) && (s3_mid_reg < s3_last_reg))
    `LGCG_ASSERT_NEXT(a_freeze, clk, rst_n, out_valid_reg && out_stall, $stable(s1_ctl_reg.valid) && $stable(p_ctl_reg.valid))

endmodule

FILE: design/led_two_color_gradient_unit.sv
// top level of the led two color gradient unit
// depends on lgcg_pkg, lgcg_front, lgcg_fifo, lgcg_back
//
// Usage: each input transaction carries a frame offset and an led index;
// each output transaction returns that led's red, green and blue bytes
// blended between color_first and color_second, with pixel_index echoing
// the led index. Results come back in request order, one per request.
// Configuration is written over a separate channel (cfg_valid/cfg_ready,
// cfg_index selects the register); the user must write it only while no
// request is in flight, which the block does not enforce; cfg_ready is always high.
// The fraction divider is fully pipelined with one stage per quotient bit,
// so one transaction is accepted every clock while in_stall is low.
// When out_valid and out_stall are both high the back pipeline holds;
// a four-entry queue then fills and in_stall rises once it and the front
// register are full.
// Reset clears all valid flags and sets mode linear, no reversal,
// led_count 1 and both colors black.
module led_two_color_gradient_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lgcg_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [lgcg_pkg::COL_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lgcg_pkg::OFF_W-1:0]     offset,
    input  logic [lgcg_pkg::IDX_W-1:0]     led_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lgcg_pkg::CH_W-1:0]      red,
    output logic [lgcg_pkg::CH_W-1:0]      green,
    output logic [lgcg_pkg::CH_W-1:0]      blue,
    output logic [lgcg_pkg::IDX_W-1:0]     pixel_index
);
    import lgcg_pkg::*;

    cfg_t  cfg_reg;
    logic  push;
    item_t push_item;
    item_t head_item;
    logic  pop;
    logic  not_empty;
    logic  fifo_full;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= MODE_LINEAR;
            cfg_reg.reverse_order <= 1'b0;
            cfg_reg.led_count <= CNT_W'(1);
            cfg_reg.color_first <= '0;
            cfg_reg.color_second <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:         cfg_reg.mode <= cfg_data[1:0];
                REG_REVERSE:      cfg_reg.reverse_order <= cfg_data[0];
                REG_COUNT:        cfg_reg.led_count <= cfg_data[CNT_W-1:0];
                REG_COLOR_FIRST:  cfg_reg.color_first <= cfg_data;
                REG_COLOR_SECOND: cfg_reg.color_second <= cfg_data;
                default:          ;
            endcase
        end
    end

    lgcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .offset    (offset),
        .led_index (led_index),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    lgcg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty),
        .full      (fifo_full)
    );

    lgcg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_item   (head_item),
        .not_empty   (not_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pixel_index (pixel_index)
    );

endmodule
